// ----- rtl/chsa_pkg.sv -----
`default_nettype none

package chsa_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int DOY_W   = 9;
   localparam int STEP_W  = 5;
   localparam int SUM_W   = 6;

   localparam logic [YEAR_W-1:0]  MAX_YEAR      = YEAR_W'(9999);
   localparam logic [MONTH_W-1:0] MONTHS        = MONTH_W'(12);
   localparam logic [HOUR_W-1:0]  MAX_HOUR      = HOUR_W'(23);
   localparam logic [STEP_W-1:0]  MAX_STEP      = STEP_W'(24);
   localparam logic [SUM_W-1:0]   HOURS_PER_DAY = SUM_W'(24);
   localparam logic [DAY_W-1:0]   LEAP_FEB_LEN  = DAY_W'(29);

   // floor(y / 25) == (y * RECIP_K) >> RECIP_SHIFT for every 14-bit y
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_W     = 15;
   localparam int PROD_W      = YEAR_W + RECIP_W;
   localparam int QUOT_W      = 10;
   localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(20972);

   localparam logic [DAY_W-1:0] MONTH_LEN [12] =
      '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

   localparam logic [DOY_W-1:0] DAYS_BEFORE [12] =
      '{9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [HOUR_W-1:0]  hour;
   } req_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  next_year;
      logic [MONTH_W-1:0] next_month;
      logic [DAY_W-1:0]   next_day;
      logic [HOUR_W-1:0]  next_hour;
      logic [DOY_W-1:0]   day_of_year;
      logic               is_leap;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/calendar_hour_step_advance_core.sv -----
`default_nettype none

// Adds the programmed hour step (csr_wdata, 1..24; 0 acts as 1, above 24 as 24) to a
// Gregorian date and hour, rolling day, month and year (9999 wraps to 0), and returns the
// day of year and leap flag of the new date. Each item passes through the stages in order:
// stage 1 clamps the input, adds the step and runs the reciprocal multiplies for the
// divide-by-25 in the leap test, stage 2 finishes the leap test and does the day/month/year
// rollover, stage 3 adds up the day of year into the output register. One item is accepted
// per clock; back-pressure on rsp_ready stalls the stages in place with nothing lost.
module calendar_hour_step_advance_core (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire chsa_pkg::req_type       req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output chsa_pkg::rsp_type            rsp_data,
   input  wire                          csr_we,
   input  wire [chsa_pkg::STEP_W-1:0]   csr_wdata
);

   logic [chsa_pkg::STEP_W-1:0] step_ff;

   // stage enables
   logic en1, en2, en3;

   // stage 1 registers
   logic                           s1_valid_ff;
   logic [chsa_pkg::YEAR_W-1:0]    s1_year_ff,  s1_year_in;
   logic [chsa_pkg::YEAR_W-1:0]    s1_nyear_ff, s1_nyear_in;
   logic [chsa_pkg::PROD_W-1:0]    s1_prod_ff,  s1_prod_in;
   logic [chsa_pkg::PROD_W-1:0]    s1_nprod_ff, s1_nprod_in;
   logic [chsa_pkg::MONTH_W-1:0]   s1_month_ff, s1_month_in;
   logic [chsa_pkg::DAY_W-1:0]     s1_day_ff,   s1_day_in;
   logic [chsa_pkg::HOUR_W-1:0]    s1_hour_ff,  s1_hour_in;
   logic                           s1_carry_ff, s1_carry_in;

   // stage 2 registers
   logic                           s2_valid_ff;
   logic [chsa_pkg::YEAR_W-1:0]    s2_year_ff,  s2_year_in;
   logic [chsa_pkg::MONTH_W-1:0]   s2_month_ff, s2_month_in;
   logic [chsa_pkg::DAY_W-1:0]     s2_day_ff,   s2_day_in;
   logic [chsa_pkg::HOUR_W-1:0]    s2_hour_ff;
   logic                           s2_leap_ff,  s2_leap_in;

   // stage 3 (output) registers
   logic                           s3_valid_ff;
   chsa_pkg::rsp_type              s3_data_ff, s3_data_in;

   assign en3       = !s3_valid_ff || rsp_ready;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign req_ready = en1;
   assign rsp_valid = s3_valid_ff;
   assign rsp_data  = s3_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= chsa_pkg::STEP_W'(1);
      end else if (csr_we) begin
         step_ff <= csr_wdata;
      end
   end

   // ---------------- stage 1: clamp, add step, reciprocal multiply
   logic [chsa_pkg::STEP_W-1:0] step_c;
   logic [chsa_pkg::SUM_W-1:0]  sum;

   always_comb begin
      if (req_data.year > chsa_pkg::MAX_YEAR) begin
         s1_year_in = chsa_pkg::MAX_YEAR;
      end else begin
         s1_year_in = req_data.year;
      end
      if (s1_year_in >= chsa_pkg::MAX_YEAR) begin
         s1_nyear_in = '0;
      end else begin
         s1_nyear_in = s1_year_in + chsa_pkg::YEAR_W'(1);
      end
      s1_prod_in  = chsa_pkg::PROD_W'(s1_year_in) * chsa_pkg::PROD_W'(chsa_pkg::RECIP_K);
      s1_nprod_in = chsa_pkg::PROD_W'(s1_nyear_in) * chsa_pkg::PROD_W'(chsa_pkg::RECIP_K);

      if (req_data.month == '0) begin
         s1_month_in = chsa_pkg::MONTH_W'(1);
      end else if (req_data.month > chsa_pkg::MONTHS) begin
         s1_month_in = chsa_pkg::MONTHS;
      end else begin
         s1_month_in = req_data.month;
      end

      // upper clamp of the day needs the month length, done in stage 2
      if (req_data.day == '0) begin
         s1_day_in = chsa_pkg::DAY_W'(1);
      end else begin
         s1_day_in = req_data.day;
      end

      if (step_ff == '0) begin
         step_c = chsa_pkg::STEP_W'(1);
      end else if (step_ff > chsa_pkg::MAX_STEP) begin
         step_c = chsa_pkg::MAX_STEP;
      end else begin
         step_c = step_ff;
      end

      if (req_data.hour > chsa_pkg::MAX_HOUR) begin
         sum = chsa_pkg::SUM_W'(chsa_pkg::MAX_HOUR) + chsa_pkg::SUM_W'(step_c);
      end else begin
         sum = chsa_pkg::SUM_W'(req_data.hour) + chsa_pkg::SUM_W'(step_c);
      end
      s1_carry_in = (sum >= chsa_pkg::HOURS_PER_DAY);
      if (s1_carry_in) begin
         s1_hour_in = chsa_pkg::HOUR_W'(sum - chsa_pkg::HOURS_PER_DAY);
      end else begin
         s1_hour_in = chsa_pkg::HOUR_W'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_year_ff  <= s1_year_in;
         s1_nyear_ff <= s1_nyear_in;
         s1_prod_ff  <= s1_prod_in;
         s1_nprod_ff <= s1_nprod_in;
         s1_month_ff <= s1_month_in;
         s1_day_ff   <= s1_day_in;
         s1_hour_ff  <= s1_hour_in;
         s1_carry_ff <= s1_carry_in;
      end
   end

   // ---------------- stage 2: leap test, rollover
   logic [chsa_pkg::QUOT_W-1:0]  q_cur, q_nxt;
   logic [chsa_pkg::YEAR_W-1:0]  r_cur, r_nxt;
   logic                         leap_cur, leap_nxt;
   logic [chsa_pkg::DAY_W-1:0]   len;
   logic [chsa_pkg::DAY_W-1:0]   day_c;
   logic [chsa_pkg::MONTH_W-1:0] m_idx;

   // leap: (y%4==0 && y%25!=0) || (y%16==0 && y%25==0)
   function automatic logic leap_of(input logic [chsa_pkg::YEAR_W-1:0] y,
                                    input logic [chsa_pkg::YEAR_W-1:0] r25);
      logic d25;
      d25 = (r25 == '0);
      return ((y[1:0] == 2'b00) && !d25) || ((y[3:0] == 4'b0000) && d25);
   endfunction

   always_comb begin
      q_cur = s1_prod_ff[chsa_pkg::RECIP_SHIFT +: chsa_pkg::QUOT_W];
      q_nxt = s1_nprod_ff[chsa_pkg::RECIP_SHIFT +: chsa_pkg::QUOT_W];
      r_cur = s1_year_ff - ((chsa_pkg::YEAR_W'(q_cur) << 4) + (chsa_pkg::YEAR_W'(q_cur) << 3)
                            + chsa_pkg::YEAR_W'(q_cur));
      r_nxt = s1_nyear_ff - ((chsa_pkg::YEAR_W'(q_nxt) << 4) + (chsa_pkg::YEAR_W'(q_nxt) << 3)
                             + chsa_pkg::YEAR_W'(q_nxt));
      leap_cur = leap_of(s1_year_ff, r_cur);
      leap_nxt = leap_of(s1_nyear_ff, r_nxt);

      m_idx = s1_month_ff - chsa_pkg::MONTH_W'(1);
      if ((s1_month_ff == chsa_pkg::MONTH_W'(2)) && leap_cur) begin
         len = chsa_pkg::LEAP_FEB_LEN;
      end else begin
         len = chsa_pkg::MONTH_LEN[m_idx];
      end
      day_c = (s1_day_ff > len) ? len : s1_day_ff;

      s2_year_in  = s1_year_ff;
      s2_month_in = s1_month_ff;
      s2_day_in   = day_c;
      s2_leap_in  = leap_cur;
      if (s1_carry_ff) begin
         if (day_c == len) begin
            s2_day_in = chsa_pkg::DAY_W'(1);
            if (s1_month_ff == chsa_pkg::MONTHS) begin
               s2_month_in = chsa_pkg::MONTH_W'(1);
               s2_year_in  = s1_nyear_ff;
               s2_leap_in  = leap_nxt;
            end else begin
               s2_month_in = s1_month_ff + chsa_pkg::MONTH_W'(1);
            end
         end else begin
            s2_day_in = day_c + chsa_pkg::DAY_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_year_ff  <= s2_year_in;
         s2_month_ff <= s2_month_in;
         s2_day_ff   <= s2_day_in;
         s2_hour_ff  <= s1_hour_ff;
         s2_leap_ff  <= s2_leap_in;
      end
   end

   // ---------------- stage 3: day of year
   logic [chsa_pkg::MONTH_W-1:0] m2_idx;

   always_comb begin
      m2_idx                 = s2_month_ff - chsa_pkg::MONTH_W'(1);
      s3_data_in.next_year   = s2_year_ff;
      s3_data_in.next_month  = s2_month_ff;
      s3_data_in.next_day    = s2_day_ff;
      s3_data_in.next_hour   = s2_hour_ff;
      s3_data_in.is_leap     = s2_leap_ff;
      s3_data_in.day_of_year = chsa_pkg::DAYS_BEFORE[m2_idx]
                               + chsa_pkg::DOY_W'(s2_day_ff)
                               + chsa_pkg::DOY_W'((s2_month_ff > chsa_pkg::MONTH_W'(2))
                                                  && s2_leap_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_data_ff <= s3_data_in;
      end
   end

   // ---------------- checks
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted item did not reach stage 1");

   a_hour_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.next_hour < chsa_pkg::HOUR_W'(24)))
      else $error("next_hour out of range");

   a_doy_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.day_of_year != '0) &&
                     (rsp_data.day_of_year <= chsa_pkg::DOY_W'(365)
                      + chsa_pkg::DOY_W'(rsp_data.is_leap))))
      else $error("day_of_year out of range");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.next_month != '0) &&
                     (rsp_data.next_month <= chsa_pkg::MONTHS)))
      else $error("next_month out of range");

endmodule

`default_nettype wire

// ----- tb/date_advance_checker.sv -----
module date_advance_checker (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   input  wire                         req_ready,
   input  chsa_pkg::req_type           req_data,
   input  wire                         rsp_valid,
   input  wire                         rsp_ready,
   input  chsa_pkg::rsp_type           rsp_data,
   input  wire                         csr_we,
   input  wire [chsa_pkg::STEP_W-1:0]  csr_wdata,
   output int                          results_seen,
   output int                          error_count
);

   localparam int unsigned LAST_YEAR   = 9999;
   localparam int unsigned DAY_HOURS   = 24;
   localparam int unsigned LONGEST_STEP = 24;

   localparam int unsigned DAYS_IN [12] =
      '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   localparam int unsigned ORDINAL_BASE [12] =
      '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   logic [chsa_pkg::STEP_W-1:0] step_reg;
   chsa_pkg::rsp_type           expected_dates [$];

   function automatic bit leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic chsa_pkg::rsp_type advance_date(chsa_pkg::req_type cur,
                                                      logic [chsa_pkg::STEP_W-1:0] step);
      int unsigned       y, m, d, h, s, len, total, doy;
      chsa_pkg::rsp_type nxt;
      y = cur.year;
      m = cur.month;
      d = cur.day;
      h = cur.hour;
      s = step;
      if (s == 0) s = 1;
      if (s > LONGEST_STEP) s = LONGEST_STEP;
      if (y > LAST_YEAR) y = LAST_YEAR;
      if (m == 0) m = 1;
      if (m > 12) m = 12;
      len = (m == 2 && leap_year(y)) ? 29 : DAYS_IN[m-1];
      if (d == 0) d = 1;
      if (d > len) d = len;
      if (h > 23) h = 23;

      total = h + s;
      if (total >= DAY_HOURS) begin
         total = total - DAY_HOURS;
         d = d + 1;
         if (d > len) begin
            d = 1;
            m = m + 1;
            if (m > 12) begin
               m = 1;
               y = (y == LAST_YEAR) ? 0 : y + 1;
            end
         end
      end

      doy = ORDINAL_BASE[m-1] + d;
      if (m > 2 && leap_year(y)) doy = doy + 1;

      nxt.next_year   = chsa_pkg::YEAR_W'(y);
      nxt.next_month  = chsa_pkg::MONTH_W'(m);
      nxt.next_day    = chsa_pkg::DAY_W'(d);
      nxt.next_hour   = chsa_pkg::HOUR_W'(total);
      nxt.day_of_year = chsa_pkg::DOY_W'(doy);
      nxt.is_leap     = leap_year(y);
      return nxt;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      chsa_pkg::rsp_type want;
      if (reset) begin
         step_reg = chsa_pkg::STEP_W'(1);
         expected_dates.delete();
         results_seen <= 0;
         error_count = 0;
      end else begin
         if (req_valid && req_ready)
            expected_dates.push_back(advance_date(req_data, step_reg));
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (expected_dates.size() == 0) begin
               $error("result item with nothing outstanding: %p", rsp_data);
               error_count++;
            end else begin
               want = expected_dates.pop_front();
               check_field("next_year",   want.next_year,   rsp_data.next_year);
               check_field("next_month",  want.next_month,  rsp_data.next_month);
               check_field("next_day",    want.next_day,    rsp_data.next_day);
               check_field("next_hour",   want.next_hour,   rsp_data.next_hour);
               check_field("day_of_year", want.day_of_year, rsp_data.day_of_year);
               check_field("is_leap",     want.is_leap,     rsp_data.is_leap);
            end
         end
         // step only changes while nothing is in flight
         if (csr_we) step_reg = csr_wdata;
      end
   end

endmodule

// ----- tb/testbench.sv -----
module testbench;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 100;
   localparam int PHASES       = 8;
   localparam logic [chsa_pkg::STEP_W-1:0] PHASE_STEPS [PHASES] =
      '{5'd24, 5'd0, 5'd31, 5'd7, 5'd1, 5'd25, 5'd13, 5'd23};

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_valid  = 1'b0;
   logic                        req_ready;
   chsa_pkg::req_type           req_data   = '0;
   logic                        rsp_valid;
   logic                        rsp_ready  = 1'b0;
   chsa_pkg::rsp_type           rsp_data;
   logic                        csr_we     = 1'b0;
   logic [chsa_pkg::STEP_W-1:0] csr_wdata  = '0;

   int results_seen;
   int error_count;
   int items_sent      = 0;
   int cycle_count     = 0;
   int stall_left      = 0;
   bit sender_idling   = 1'b1;
   bit receiver_idling = 1'b1;

   always #5 clock = ~clock;

   calendar_hour_step_advance_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   date_advance_checker date_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .results_seen (results_seen),
      .error_count  (error_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // result side stalls in random bursts while receiver_idling is set
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (receiver_idling && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 13);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_date(input chsa_pkg::req_type item);
      int gap;
      if (sender_idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (results_seen < items_sent) @(posedge clock);
   endtask

   task automatic set_step(input logic [chsa_pkg::STEP_W-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic chsa_pkg::req_type date_of(int y, int m, int d, int h);
      chsa_pkg::req_type r;
      r.year  = chsa_pkg::YEAR_W'(y);
      r.month = chsa_pkg::MONTH_W'(m);
      r.day   = chsa_pkg::DAY_W'(d);
      r.hour  = chsa_pkg::HOUR_W'(h);
      return r;
   endfunction

   // mostly legal dates, weighted toward month ends, late hours, February,
   // December and century years; a few out-of-range fields
   function automatic chsa_pkg::req_type random_date();
      chsa_pkg::req_type r;
      case ($urandom_range(0, 7))
         0:       r.year = chsa_pkg::YEAR_W'($urandom_range(0, 16383));
         1:       r.year = chsa_pkg::YEAR_W'($urandom_range(0, 99) * 100);
         2:       r.year = chsa_pkg::YEAR_W'(9999);
         default: r.year = chsa_pkg::YEAR_W'($urandom_range(0, 9999));
      endcase
      case ($urandom_range(0, 7))
         0:       r.month = chsa_pkg::MONTH_W'($urandom);
         1:       r.month = chsa_pkg::MONTH_W'(2);
         2:       r.month = chsa_pkg::MONTH_W'(12);
         default: r.month = chsa_pkg::MONTH_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 7))
         0:          r.day = chsa_pkg::DAY_W'($urandom);
         1, 2, 3:    r.day = chsa_pkg::DAY_W'($urandom_range(27, 31));
         default:    r.day = chsa_pkg::DAY_W'($urandom_range(1, 28));
      endcase
      case ($urandom_range(0, 7))
         0:          r.hour = chsa_pkg::HOUR_W'($urandom);
         1, 2, 3:    r.hour = chsa_pkg::HOUR_W'($urandom_range(20, 23));
         default:    r.hour = chsa_pkg::HOUR_W'($urandom_range(0, 23));
      endcase
      return r;
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // step left at its reset value
      send_date(date_of(0, 1, 1, 0));
      send_date(date_of(2023, 12, 31, 23));
      send_date(date_of(9999, 12, 31, 23));
      send_date(date_of(2024, 2, 28, 23));
      send_date(date_of(1900, 2, 28, 23));
      send_date(date_of(2000, 2, 29, 23));
      send_date(date_of(16383, 15, 0, 31));
      send_date(date_of(2023, 0, 31, 22));
      send_date(date_of(2023, 4, 31, 23));
      send_date(date_of(2023, 2, 31, 23));
      send_date(date_of(2100, 2, 29, 12));
      send_date(date_of(2024, 12, 31, 10));

      set_step(chsa_pkg::STEP_W'(24));
      send_date(date_of(2024, 12, 31, 0));
      send_date(date_of(2024, 6, 30, 23));
      send_date(date_of(1600, 2, 29, 5));
      send_date(date_of(9999, 12, 31, 0));
      send_date(date_of(10000, 13, 31, 31));

      set_step(chsa_pkg::STEP_W'(0));
      send_date(date_of(2023, 12, 31, 23));
      send_date(date_of(2023, 3, 1, 0));

      set_step(chsa_pkg::STEP_W'(31));
      send_date(date_of(2023, 1, 31, 0));
      send_date(date_of(2023, 11, 30, 23));

      for (int phase = 0; phase < PHASES; phase++) begin
         set_step(PHASE_STEPS[phase]);
         // phase 3 and the last phase run without gaps on both sides
         sender_idling   <= (phase != 3) && (phase != PHASES - 1);
         receiver_idling <= (phase != 3) && (phase != PHASES - 1);
         repeat (PHASE_ITEMS) send_date(random_date());
      end

      drain();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/chsa_pkg.sv
rtl/calendar_hour_step_advance_core.sv
tb/date_advance_checker.sv
tb/testbench.sv
